FILE: design/cags_pkg.sv
// shared types and constants for the cave automaton generation step
package cags_pkg;

    localparam int ROW_W        = 64;
    localparam int TH_W         = 4;
    localparam int COLS_DEF     = 64;
    localparam int QUEUE_DEPTH  = 2;

    localparam logic [TH_W-1:0] BIRTH_RESET   = 4'd5;
    localparam logic [TH_W-1:0] SURVIVE_RESET = 4'd4;

    // register indexes on the configuration port
    localparam logic REG_BIRTH   = 1'b0;
    localparam logic REG_SURVIVE = 1'b1;

    // thresholds handed to the cell update
    typedef struct packed {
        logic [TH_W-1:0] birth;
        logic [TH_W-1:0] survive;
    } t_cfg;

    // one row job: three rows plus how to emit it
    typedef struct packed {
        logic [ROW_W-1:0] above;
        logic [ROW_W-1:0] mid;
        logic [ROW_W-1:0] below;
        logic             pair;      // emit a second row shifted down by one
        logic             last_out;  // first emitted row closes the generation
    } t_job;

endpackage

FILE: design/cave_automaton_generation_step.sv
// top level: cave automaton generation step, front, job queue, back and config registers
//
//  channel   direction  handshake          payload
//  s_*       in         s_tvalid/s_tready  s_tdata row_cells, s_tlast last_row
//  m_*       out        m_tvalid/m_tready  m_tdata next_row_cells, m_tlast last_out
//  apb       in         psel/penable       paddr, pwdata (birth at 0x0, survive at 0x4)
//
//  one item per cycle in and one result row per cycle out when nothing stalls
//  a final row after other rows makes two result rows, which the back end emits one after the other
//  the item that completes a result passes through the queue, then the output register
//  reset is synchronous, active low: row window empty, thresholds birth 5 and survive 4
//  a stall on m_tready fills the queue, then s_tready drops; no clearing pass after reset
module cave_automaton_generation_step #(
    parameter int COLS        = cags_pkg::COLS_DEF,
    parameter int QUEUE_DEPTH = cags_pkg::QUEUE_DEPTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [cags_pkg::ROW_W-1:0] s_tdata,   // [63:0] row_cells
    input  logic                       s_tlast,   // last_row
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [cags_pkg::ROW_W-1:0] m_tdata,   // [63:0] next_row_cells
    output logic                       m_tlast,   // last_out
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [2:0]                 paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    cags_pkg::t_cfg r_cfg;
    cags_pkg::t_job front_job, head_job;
    logic           push, full, head_valid, pop;
    logic           reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = paddr[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.birth   <= cags_pkg::BIRTH_RESET;
            r_cfg.survive <= cags_pkg::SURVIVE_RESET;
        end else if (psel && penable && pwrite && pready) begin
            case (reg_sel)
                cags_pkg::REG_BIRTH:   r_cfg.birth   <= pwdata[cags_pkg::TH_W-1:0];
                cags_pkg::REG_SURVIVE: r_cfg.survive <= pwdata[cags_pkg::TH_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            cags_pkg::REG_BIRTH:   prdata = {{(32-cags_pkg::TH_W){1'b0}}, r_cfg.birth};
            cags_pkg::REG_SURVIVE: prdata = {{(32-cags_pkg::TH_W){1'b0}}, r_cfg.survive};
            default:               prdata = '0;
        endcase
    end

    cags_front #(.COLS(COLS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_tvalid),
        .o_ready (s_tready),
        .i_row   (s_tdata),
        .i_last  (s_tlast),
        .i_full  (full),
        .o_push  (push),
        .o_job   (front_job)
    );

    cags_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (head_valid),
        .o_job   (head_job)
    );

    cags_back #(.COLS(COLS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_job_valid (head_valid),
        .i_job       (head_job),
        .o_pop       (pop),
        .o_valid     (m_tvalid),
        .i_ready     (m_tready),
        .o_row       (m_tdata),
        .o_last      (m_tlast)
    );

endmodule

FILE: design/cags_front.sv
// front end: row window and job build per accepted item
module cags_front #(
    parameter int COLS = cags_pkg::COLS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [cags_pkg::ROW_W-1:0] i_row,
    input  logic                       i_last,
    input  logic                       i_full,
    output logic                       o_push,
    output cags_pkg::t_job             o_job
);

    localparam logic [cags_pkg::ROW_W-1:0] ColMask =
        {cags_pkg::ROW_W{1'b1}} >> (cags_pkg::ROW_W - COLS);
    localparam logic [cags_pkg::ROW_W-1:0] Ones = {cags_pkg::ROW_W{1'b1}};

    localparam logic [1:0] SEEN_NONE = 2'd0;
    localparam logic [1:0] SEEN_ONE  = 2'd1;
    localparam logic [1:0] SEEN_TWO  = 2'd2;

    logic [cags_pkg::ROW_W-1:0] r_prev, n_prev;
    logic [cags_pkg::ROW_W-1:0] r_prev2, n_prev2;
    logic [1:0]                 r_seen, n_seen;
    logic [cags_pkg::ROW_W-1:0] row;
    logic                       accept;

    assign o_ready = !i_full;
    assign accept  = i_valid && o_ready;
    assign row     = i_row & ColMask;

    always_comb begin
        n_prev  = r_prev;
        n_prev2 = r_prev2;
        n_seen  = r_seen;
        o_push  = 1'b0;
        o_job   = '0;
        if (r_seen == SEEN_NONE) begin
            // single row grid: outside rows above and below
            o_job.above    = Ones;
            o_job.mid      = row;
            o_job.below    = Ones;
            o_job.pair     = 1'b0;
            o_job.last_out = 1'b1;
        end else begin
            o_job.above    = (r_seen == SEEN_ONE) ? Ones : r_prev2;
            o_job.mid      = r_prev;
            o_job.below    = row;
            o_job.pair     = i_last;
            o_job.last_out = 1'b0;
        end
        if (accept) begin
            o_push = (r_seen != SEEN_NONE) || i_last;
            if (i_last) begin
                n_prev  = '0;
                n_prev2 = '0;
                n_seen  = SEEN_NONE;
            end else begin
                n_prev  = row;
                n_prev2 = r_prev;
                n_seen  = (r_seen == SEEN_NONE) ? SEEN_ONE : SEEN_TWO;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev  <= '0;
            r_prev2 <= '0;
            r_seen  <= SEEN_NONE;
        end else begin
            r_prev  <= n_prev;
            r_prev2 <= n_prev2;
            r_seen  <= n_seen;
        end
    end

endmodule

FILE: design/cags_queue.sv
// short job queue between front and back
module cags_queue #(
    parameter int DEPTH = cags_pkg::QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  cags_pkg::t_job i_job,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output cags_pkg::t_job o_job
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [IW-1:0] LastIdx = IW'(DEPTH - 1);
    localparam logic [CW-1:0] FullCnt = CW'(DEPTH);

    cags_pkg::t_job r_mem [DEPTH];
    logic [IW-1:0]  r_wr, n_wr;
    logic [IW-1:0]  r_rd, n_rd;
    logic [CW-1:0]  r_cnt, n_cnt;
    logic           do_push, do_pop;

    assign o_full  = (r_cnt == FullCnt);
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == LastIdx) ? '0 : r_wr + 1'b1;
        end
        if (do_pop) begin
            n_rd = (r_rd == LastIdx) ? '0 : r_rd + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

FILE: design/cags_back.sv
// back end: per-cell neighbour count and threshold, registered output row
module cags_back #(
    parameter int COLS = cags_pkg::COLS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  cags_pkg::t_cfg             i_cfg,
    input  logic                       i_job_valid,
    input  cags_pkg::t_job             i_job,
    output logic                       o_pop,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [cags_pkg::ROW_W-1:0] o_row,
    output logic                       o_last
);

    localparam logic [cags_pkg::ROW_W-1:0] Ones = {cags_pkg::ROW_W{1'b1}};

    logic                       r_phase;
    logic                       r_valid;
    logic [cags_pkg::ROW_W-1:0] r_row;
    logic                       r_last;
    logic [cags_pkg::ROW_W-1:0] above, mid, below;
    logic [COLS+1:0]            ext_a, ext_m, ext_b;
    logic [cags_pkg::ROW_W-1:0] n_row;
    logic                       n_last;
    logic                       load;
    logic [cags_pkg::TH_W-1:0]  cnt  [COLS];
    logic [cags_pkg::TH_W-1:0]  thr  [COLS];

    // second row of a pair: window slides down with an outside row below
    assign above  = r_phase ? i_job.mid : i_job.above;
    assign mid    = r_phase ? i_job.below : i_job.mid;
    assign below  = r_phase ? Ones : i_job.below;
    assign n_last = r_phase ? 1'b1 : i_job.last_out;

    // columns off either edge count as alive
    assign ext_a = {1'b1, above[COLS-1:0], 1'b1};
    assign ext_m = {1'b1, mid[COLS-1:0], 1'b1};
    assign ext_b = {1'b1, below[COLS-1:0], 1'b1};

    always_comb begin
        n_row = '0;
        for (int c = 0; c < COLS; c++) begin
            cnt[c] = cags_pkg::TH_W'(ext_a[c]) + cags_pkg::TH_W'(ext_a[c+1])
                   + cags_pkg::TH_W'(ext_a[c+2]) + cags_pkg::TH_W'(ext_m[c])
                   + cags_pkg::TH_W'(ext_m[c+2]) + cags_pkg::TH_W'(ext_b[c])
                   + cags_pkg::TH_W'(ext_b[c+1]) + cags_pkg::TH_W'(ext_b[c+2]);
            thr[c] = ext_m[c+1] ? i_cfg.survive : i_cfg.birth;
            n_row[c] = (cnt[c] >= thr[c]);
        end
    end

    assign load  = i_job_valid && (!r_valid || i_ready);
    assign o_pop = load && (!i_job.pair || r_phase);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_phase <= i_job.pair && !r_phase;
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_row  <= n_row;
            r_last <= n_last;
        end
    end

    assign o_valid = r_valid;
    assign o_row   = r_row;
    assign o_last  = r_last;

endmodule

FILE: tb/tb_top.sv
// testbench for the cave automaton generation step: row stream, apb thresholds, result checks
`timescale 1ns / 100ps

module tb_top;

    localparam logic [cags_pkg::ROW_W-1:0] ALL_ALIVE = '1;
    localparam int DRAIN_CYCLES = 6;
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        logic [cags_pkg::ROW_W-1:0] cells;
        logic                       is_last;
    } t_row_result;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       s_tvalid;
    logic                       s_tready;
    logic [cags_pkg::ROW_W-1:0] s_tdata;   // [63:0] row_cells
    logic                       s_tlast;   // last_row
    logic                       m_tvalid;
    logic                       m_tready;
    logic [cags_pkg::ROW_W-1:0] m_tdata;   // [63:0] next_row_cells
    logic                       m_tlast;   // last_out
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [2:0]                 paddr;
    logic [31:0]                pwdata;
    logic [31:0]                prdata;
    logic                       pready;

    cave_automaton_generation_step u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // automaton state as the block should hold it
    logic [cags_pkg::TH_W-1:0]  birth_thr;
    logic [cags_pkg::TH_W-1:0]  survive_thr;
    logic [cags_pkg::ROW_W-1:0] held_mid;
    logic [cags_pkg::ROW_W-1:0] held_above;
    int                         rows_held;

    t_row_result expected_rows[$];

    int send_idle_pct;
    int recv_idle_pct;
    int mismatches;
    int rows_sent;
    int grids_sent;
    int results_seen;
    int settings_used;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #(4_000_000);
        $display("cave_automaton_generation_step test failed");
        $finish;
    end

    always @(negedge i_clk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic flag_mismatch(input string what);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("mismatch at %0t: %s", $time, what);
    endtask

    // one generation of one cell row, outside cells alive on both sides
    function automatic logic [cags_pkg::ROW_W-1:0] next_generation(
        input logic [cags_pkg::ROW_W-1:0] above,
        input logic [cags_pkg::ROW_W-1:0] mid,
        input logic [cags_pkg::ROW_W-1:0] below);
        logic [cags_pkg::ROW_W+1:0] a;
        logic [cags_pkg::ROW_W+1:0] m;
        logic [cags_pkg::ROW_W+1:0] b;
        logic [cags_pkg::ROW_W-1:0] res;
        logic [cags_pkg::TH_W-1:0]  thr;
        int                         n;
        a = {1'b1, above, 1'b1};
        m = {1'b1, mid, 1'b1};
        b = {1'b1, below, 1'b1};
        for (int c = 0; c < cags_pkg::ROW_W; c++) begin
            n = 0;
            for (int d = 0; d < 3; d++) begin
                n += int'(a[c+d]);
                n += int'(b[c+d]);
            end
            n += int'(m[c]);
            n += int'(m[c+2]);
            thr = m[c+1] ? survive_thr : birth_thr;
            res[c] = (n >= int'(thr));
        end
        return res;
    endfunction

    task automatic predict_row(input logic [cags_pkg::ROW_W-1:0] row, input logic is_last);
        if (rows_held == 0) begin
            if (is_last)
                expected_rows.push_back('{cells: next_generation(ALL_ALIVE, row, ALL_ALIVE),
                                          is_last: 1'b1});
        end else begin
            expected_rows.push_back('{cells: next_generation(rows_held == 1 ? ALL_ALIVE
                                                             : held_above, held_mid, row),
                                      is_last: 1'b0});
            if (is_last)
                expected_rows.push_back('{cells: next_generation(held_mid, row, ALL_ALIVE),
                                          is_last: 1'b1});
        end
        if (is_last) begin
            held_mid   = '0;
            held_above = '0;
            rows_held  = 0;
        end else begin
            held_above = held_mid;
            held_mid   = row;
            rows_held  = (rows_held == 0) ? 1 : 2;
        end
    endtask

    always @(posedge i_clk) begin : check_results
        t_row_result want;
        if (i_rst_n && m_tvalid && m_tready) begin
            results_seen++;
            if (expected_rows.size() == 0) begin
                flag_mismatch($sformatf("unexpected row %h last %b", m_tdata, m_tlast));
            end else begin
                want = expected_rows.pop_front();
                if (m_tdata !== want.cells)
                    flag_mismatch($sformatf("row expected %h got %h", want.cells, m_tdata));
                if (m_tlast !== want.is_last)
                    flag_mismatch($sformatf("last expected %b got %b", want.is_last, m_tlast));
            end
        end
    end

    task automatic send_row(input logic [cags_pkg::ROW_W-1:0] row, input logic is_last);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= row;
        s_tlast  <= is_last;
        do @(posedge i_clk); while (!s_tready);
        predict_row(row, is_last);
        rows_sent++;
        if (is_last)
            grids_sent++;
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        s_tvalid <= 1'b0;
        while (expected_rows.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // write a threshold then read it back; only called with the block idle
    task automatic write_threshold(input logic idx, input logic [cags_pkg::TH_W-1:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {{(32-cags_pkg::TH_W){1'b0}}, value};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (idx == cags_pkg::REG_BIRTH)
            birth_thr = value;
        else
            survive_thr = value;
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata[cags_pkg::TH_W-1:0] !== value)
            flag_mismatch($sformatf("register %0d read %h, written %h", idx, prdata, value));
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_thresholds(input logic [cags_pkg::TH_W-1:0] birth,
                                  input logic [cags_pkg::TH_W-1:0] survive);
        write_threshold(cags_pkg::REG_BIRTH, birth);
        write_threshold(cags_pkg::REG_SURVIVE, survive);
        settings_used++;
    endtask

    function automatic logic [cags_pkg::ROW_W-1:0] random_row();
        logic [cags_pkg::ROW_W-1:0] r;
        r = {$urandom, $urandom};
        case ($urandom_range(9))
            0: r = '0;
            1: r = ALL_ALIVE;
            2, 3: r = r & {$urandom, $urandom} & {$urandom, $urandom};
            4, 5: r = r | {$urandom, $urandom} | {$urandom, $urandom};
            default: ;
        endcase
        return r;
    endfunction

    task automatic send_random_grid(input int height);
        for (int r = 0; r < height; r++)
            send_row(random_row(), r == height - 1);
    endtask

    // reset thresholds, single-row grids, two-row grid, edges and alternating patterns
    task automatic test_directed_grids();
        send_row('0, 1'b1);
        send_row(ALL_ALIVE, 1'b1);
        send_row('0, 1'b0);
        send_row(ALL_ALIVE, 1'b1);
        send_row({32{2'b10}}, 1'b0);
        send_row({32{2'b01}}, 1'b0);
        send_row({cags_pkg::ROW_W{1'b0}} | 64'h1, 1'b1);
        send_row(64'h8000_0000_0000_0000, 1'b0);
        send_row(64'h1, 1'b0);
        send_row('0, 1'b0);
        send_row('0, 1'b0);
        send_row(ALL_ALIVE, 1'b0);
        send_row(64'h8000_0000_0000_0001, 1'b1);
        wait_drained();
    endtask

    // threshold extremes: always pass, never pass and mixed
    task automatic test_threshold_extremes();
        logic [cags_pkg::TH_W-1:0] births[7]   = '{4'd0, 4'd9, 4'd0, 4'd9, 4'd8, 4'd1, 4'd5};
        logic [cags_pkg::TH_W-1:0] survives[7] = '{4'd0, 4'd9, 4'd9, 4'd0, 4'd8, 4'd3, 4'd4};
        for (int i = 0; i < 7; i++) begin
            set_thresholds(births[i], survives[i]);
            send_random_grid(3);
            send_row(random_row(), 1'b1);
            wait_drained();
        end
    endtask

    task automatic test_random_grids(input int sender_pct, input int receiver_pct,
                                     input int n_rows);
        int stop_at;
        int next_setting;
        int h;
        send_idle_pct = sender_pct;
        recv_idle_pct = receiver_pct;
        stop_at       = rows_sent + n_rows;
        next_setting  = rows_sent;
        while (rows_sent < stop_at) begin
            if (rows_sent >= next_setting) begin
                wait_drained();
                set_thresholds(cags_pkg::TH_W'($urandom_range(9)),
                               cags_pkg::TH_W'($urandom_range(9)));
                next_setting = rows_sent + $urandom_range(160, 80);
            end
            h = ($urandom_range(9) == 0) ? $urandom_range(24, 9) : $urandom_range(8, 1);
            send_random_grid(h);
            // now and then the sender holds off until every row is out
            if ($urandom_range(7) == 0)
                wait_drained();
        end
        wait_drained();
    endtask

    initial begin
        i_rst_n       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tlast       = 1'b0;
        m_tready      = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        birth_thr     = cags_pkg::BIRTH_RESET;
        survive_thr   = cags_pkg::SURVIVE_RESET;
        held_mid      = '0;
        held_above    = '0;
        rows_held     = 0;
        mismatches    = 0;
        rows_sent     = 0;
        grids_sent    = 0;
        results_seen  = 0;
        settings_used = 1;
        send_idle_pct = 7;
        recv_idle_pct = 64;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_grids();
        test_threshold_extremes();
        test_random_grids(7, 64, 500);
        test_random_grids(64, 7, 500);
        test_random_grids(0, 0, 500);

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_rows.size() != 0)
            flag_mismatch($sformatf("%0d rows never came out", expected_rows.size()));
        $display("%0d rows in %0d grids sent, %0d result rows checked, %0d threshold settings",
                 rows_sent, grids_sent, results_seen, settings_used);
        $display("idling on either side and none, sender held off until drained; %0d mismatches",
                 mismatches);
        if (mismatches == 0)
            $display("cave_automaton_generation_step test passed");
        else
            $display("cave_automaton_generation_step test failed");
        $finish;
    end

endmodule

FILE: files.f
design/cags_pkg.sv
design/cags_front.sv
design/cags_queue.sv
design/cags_back.sv
design/cave_automaton_generation_step.sv
tb/tb_top.sv
